FILE: rtl/rbc_pkg.sv
// Shared constants and types for the rank-by-comparison-count unit.
// No dependencies; imported by every module of the block.
package rbc_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned CntW        = $clog2(MaxElements + 1);
  localparam int unsigned IdxW        = $clog2(MaxElements);
  localparam int unsigned ValueW      = 32;
  localparam int unsigned RankW       = 6;
  localparam int unsigned PosW        = 6;
  localparam int unsigned GrpSize     = 8;
  localparam int unsigned NumGrp      = (MaxElements + GrpSize - 1) / GrpSize;
  localparam int unsigned GrpW        = $clog2(GrpSize + 1);
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = $clog2(QDepth);
  localparam int unsigned QFillW      = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            pipe_busy;
    logic            shift;
  } core_stat_t;

endpackage

FILE: rtl/rbc_front.sv
// Front end: input transaction acceptance and a short item queue.
// Depends on rbc_pkg.
module rbc_front import rbc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  output logic  deq_valid_o,
  input  logic  deq_ready_i,
  output item_t item_o
);

  item_t             q_mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFillW-1:0] fill_q, fill_d;
  logic              enq, deq;

  assign in_ready_o  = (fill_q != QFillW'(QDepth));
  assign deq_valid_o = (fill_q != '0);
  assign item_o      = q_mem[rd_ptr_q];
  assign enq         = in_valid_i && in_ready_o;
  assign deq         = deq_valid_o && deq_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      fill_d = fill_q + 1'b1;
    end else if (deq && !enq) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/rbc_core.sv
// Back end: row of comparison cells, pipelined count of smaller values for
// each new cell, and the shift-out sequencer with its output register.
// Depends on rbc_pkg.
module rbc_core import rbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               deq_valid_i,
  output logic               deq_ready_o,
  input  item_t              item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RankW-1:0]   rank_o,
  output logic [PosW-1:0]    position_o,
  output logic               overflow_o,
  output logic               last_res_o,
  output core_stat_t         stat_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic signed [ValueW-1:0] val_q [MaxElements];
  logic [IdxW-1:0]          rank_q [MaxElements];
  logic [IdxW-1:0]          rank_d [MaxElements];

  logic                     state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic                     dropped_q, dropped_d;
  logic [IdxW-1:0]          emit_idx_q, emit_idx_d;

  logic                        a_vld_q;
  logic [IdxW-1:0]             a_tgt_q;
  logic [NumGrp*GrpSize-1:0]   lt_q, lt_d;
  logic                        b_vld_q;
  logic [IdxW-1:0]             b_tgt_q;
  logic [GrpW-1:0]             part_q [NumGrp];
  logic [GrpW-1:0]             part_d [NumGrp];
  logic [CntW-1:0]             sum_c;

  logic                 out_vld_q;
  logic [IdxW-1:0]      out_rank_q;
  logic [IdxW-1:0]      out_pos_q;
  logic                 out_ovf_q;
  logic                 out_last_q;

  logic pop, full, store, pipe_busy, out_free, shift, emit_last;
  logic [MaxElements-1:0] gt;

  assign deq_ready_o = (state_q == StLoad);
  assign pop         = deq_valid_i && deq_ready_o;
  assign full        = (count_q == CntW'(MaxElements));
  assign store       = pop && !full;
  assign pipe_busy   = a_vld_q || b_vld_q;
  assign out_free    = !out_vld_q || out_ready_i;
  assign shift       = (state_q == StEmit) && !pipe_busy && out_free;
  assign emit_last   = ((CntW'(emit_idx_q) + 1'b1) == count_q);

  // per-cell compares against the incoming value
  always_comb begin
    lt_d = '0;
    for (int k = 0; k < MaxElements; k++) begin
      gt[k]   = (CntW'(k) < count_q) && (val_q[k] > item_i.value);
      lt_d[k] = (CntW'(k) < count_q) && (val_q[k] < item_i.value);
    end
  end

  // group popcounts
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      part_d[g] = '0;
      for (int b = 0; b < GrpSize; b++) begin
        part_d[g] = part_d[g] + GrpW'(lt_q[g*GrpSize+b]);
      end
    end
  end

  always_comb begin
    sum_c = '0;
    for (int g = 0; g < NumGrp; g++) begin
      sum_c = sum_c + CntW'(part_q[g]);
    end
  end

  // rank counters: load, increment, late add of smaller count, shift out
  always_comb begin
    for (int k = 0; k < MaxElements; k++) begin
      rank_d[k] = rank_q[k];
      if (shift) begin
        rank_d[k] = (k == MaxElements - 1) ? '0 : rank_q[(k + 1) % MaxElements];
      end else if (store && (count_q == CntW'(k))) begin
        rank_d[k] = '0;
      end else begin
        if (store && gt[k]) begin
          rank_d[k] = rank_d[k] + 1'b1;
        end
        if (b_vld_q && (b_tgt_q == IdxW'(k))) begin
          rank_d[k] = rank_d[k] + sum_c[IdxW-1:0];
        end
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dropped_d  = dropped_q;
    emit_idx_d = emit_idx_q;
    if (pop) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
      if (item_i.last) begin
        state_d    = StEmit;
        emit_idx_d = '0;
      end
    end
    if (shift) begin
      emit_idx_d = emit_idx_q + 1'b1;
      if (emit_last) begin
        emit_idx_d = '0;
        count_d    = '0;
        dropped_d  = 1'b0;
        state_d    = StLoad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      emit_idx_q <= '0;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dropped_q  <= dropped_d;
      emit_idx_q <= emit_idx_d;
      a_vld_q    <= store;
      b_vld_q    <= a_vld_q;
      if (shift) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxElements; k++) begin
      rank_q[k] <= rank_d[k];
      if (store && (count_q == CntW'(k))) begin
        val_q[k] <= item_i.value;
      end
    end
    a_tgt_q <= count_q[IdxW-1:0];
    lt_q    <= lt_d;
    b_tgt_q <= a_tgt_q;
    part_q  <= part_d;
    if (shift) begin
      out_rank_q <= rank_q[0];
      out_pos_q  <= emit_idx_q;
      out_ovf_q  <= dropped_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rank_o      = RankW'(out_rank_q);
  assign position_o  = PosW'(out_pos_q);
  assign overflow_o  = out_ovf_q;
  assign last_res_o  = out_last_q;

  assign stat_o.count     = count_q;
  assign stat_o.pipe_busy = pipe_busy;
  assign stat_o.shift     = shift;

endmodule

FILE: rtl/rank_by_comparison_count_unit.sv
// Rank-by-comparison-count unit: collects a set of signed 32-bit values and
// emits each stored value's rank (count of strictly smaller values) in
// arrival order. Loads one value per cycle while a set is open; a 2-deep
// queue sits ahead of the cell row. Each new value is compared against every
// stored cell in the cycle it is loaded; its own count of smaller values
// settles through a two-stage popcount, the compare bits and group counts
// registered in turn. After the closing transaction, results leave one per
// cycle while the receiver is ready, by shifting the rank counters out of
// cell 0. Values beyond 64 are dropped and flag overflow on every result of
// that set. Depends on rbc_pkg, rbc_front, rbc_core.
module rank_by_comparison_count_unit import rbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RankW-1:0]         rank_o,
  output logic [PosW-1:0]          position_o,
  output logic                     overflow_o,
  output logic                     last_res_o
);

  item_t      in_item, q_item;
  logic       deq_valid, deq_ready;
  core_stat_t stat;

  assign in_item.value = value_i;
  assign in_item.last  = last_i;

  rbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (in_item),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .item_o      (q_item)
  );

  rbc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rank_o      (rank_o),
    .position_o  (position_o),
    .overflow_o  (overflow_o),
    .last_res_o  (last_res_o),
    .stat_o      (stat)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CntW'(MaxElements))
    else $error("element count above capacity");

  a_no_shift_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.shift |-> !stat.pipe_busy)
    else $error("ranks shifted out before popcount drained");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_res_o) |=> out_valid_o)
    else $error("gap inside a result burst");

  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_res_o && $rose(out_valid_o)) |-> (stat.count == '0))
    else $error("store not emptied after final result");

endmodule
